// ===== src/ktl_pkg.sv =====
package ktl_pkg;

	// Run modes between bytes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_LABEL = 2'd1;
	localparam logic [1:0] MODE_INT   = 2'd2;
	localparam logic [1:0] MODE_WORD  = 2'd3;

	// Token kinds
	localparam logic [3:0] KIND_IDENT   = 4'd0;
	localparam logic [3:0] KIND_LABEL   = 4'd1;
	localparam logic [3:0] KIND_INT     = 4'd2;
	localparam logic [3:0] KIND_KW0     = 4'd3;
	localparam logic [3:0] KIND_EQUAL   = 4'd8;
	localparam logic [3:0] KIND_PLUS    = 4'd9;
	localparam logic [3:0] KIND_LESS    = 4'd10;
	localparam logic [3:0] KIND_INVALID = 4'd11;
	localparam logic [3:0] KIND_END     = 4'd12;

	localparam int unsigned  KW_COUNT = 5;
	localparam logic [4:0]   LIVE_ALL = 5'h1F;
	localparam logic [15:0]  LEN_MAX  = 16'hFFFF;

	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_LESS  = 8'h3C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	// Keyword spellings, padded with zeros to eight bytes
	localparam logic [7:0] KW_CHARS [KW_COUNT][8] = '{
		'{8'h69, 8'h6E, 8'h70, 8'h75, 8'h74, 8'h00, 8'h00, 8'h00},  // input
		'{8'h6F, 8'h75, 8'h74, 8'h70, 8'h75, 8'h74, 8'h00, 8'h00},  // output
		'{8'h67, 8'h6F, 8'h74, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00},  // goto
		'{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // if
		'{8'h74, 8'h68, 8'h65, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00}   // then
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd5, 3'd6, 3'd4, 3'd2, 3'd4};

	// One output token
	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [7:0]  bad;
		logic        last;
	} token_t;

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic is_word(input logic [7:0] b);
		return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b inside {8'h20, [8'h09:8'h0D]};
	endfunction

	// Keep the keywords that still match after byte b at position pos
	function automatic logic [4:0] kw_live_next(input logic [4:0] live,
			input logic [15:0] pos, input logic [7:0] b);
		logic [4:0] res;
		res = '0;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (live[k] && (pos < 16'(KW_LEN[k])) && (KW_CHARS[k][pos[2:0]] == b))
				res[k] = 1'b1;
		end
		return res;
	endfunction

	// Kind of a finished word run: first live keyword of matching length
	function automatic logic [3:0] word_kind(input logic [4:0] live,
			input logic [15:0] len);
		logic [3:0] kind;
		logic       found;
		kind  = KIND_IDENT;
		found = 1'b0;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (!found && live[k] && (len == 16'(KW_LEN[k]))) begin
				kind  = KIND_KW0 + 4'(k);
				found = 1'b1;
			end
		end
		return kind;
	endfunction

endpackage

// ===== src/keyword_token_lexer.sv =====
// Byte-serial lexer: takes one source byte per request on s_axis and emits
// tokens (kind, start offset, length, offending byte) on m_axis, with tlast
// set on the last token that an input byte caused. A request with tlast set
// marks end of text: any pending run is flushed, END follows, and the lexer
// returns to its reset state. Each byte is classified and the run state is
// updated as it is taken, so one byte is taken per clock while the output
// buffer has room. Tokens leave a two-entry output buffer at one per clock
// while m_axis_tready is high; a byte that ends a run and is itself a token
// yields two tokens, and the input waits while the buffer drains. Offsets
// wrap modulo 2^OFFSET_BITS (low 16 bits shown); lengths saturate at 65535.
module keyword_token_lexer #(
	parameter int unsigned OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,   // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [3:0] token_type, [19:4] token_start, [35:20] token_length,
	// [43:36] bad_byte, [47:44] zero
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tlast    // final_of_run
);

	logic [1:0]             mode_q;
	logic [OFFSET_BITS-1:0] run_start_q;
	logic [15:0]            run_len_q;
	logic [4:0]             live_q;
	logic [OFFSET_BITS-1:0] offset_q;

	ktl_pkg::token_t slot0_q, slot1_q;
	logic [1:0]      count_q;

	logic [7:0]             b;
	logic                   eot;
	logic                   accept, pop;
	logic                   cont;
	logic                   flush_vld, tok_vld;
	ktl_pkg::token_t        flush_tok, byte_tok, r0, r1;
	logic [1:0]             n_res;
	logic [OFFSET_BITS-1:0] off_inc;
	logic [31:0]            off_ext, start_ext;

	assign b      = s_axis_tdata;
	assign eot    = s_axis_tlast;
	assign pop    = m_axis_tvalid && m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;

	// Take a request when the buffer is empty after this cycle's pop
	assign s_axis_tready = (count_q == 2'd0) || ((count_q == 2'd1) && m_axis_tready);

	assign off_inc   = offset_q + OFFSET_BITS'(1);
	assign off_ext   = 32'(offset_q);
	assign start_ext = 32'(run_start_q);

	// Classify the byte against the current run
	always_comb begin
		cont = 1'b0;
		if (mode_q == ktl_pkg::MODE_INT)
			cont = ktl_pkg::is_digit(b);
		else if (mode_q != ktl_pkg::MODE_IDLE)
			cont = ktl_pkg::is_word(b);
	end

	// Token for a run that ends here
	always_comb begin
		flush_vld        = (mode_q != ktl_pkg::MODE_IDLE) && (eot || !cont);
		flush_tok.start  = start_ext[15:0];
		flush_tok.length = run_len_q;
		flush_tok.bad    = 8'd0;
		flush_tok.last   = 1'b0;
		case (mode_q)
			ktl_pkg::MODE_LABEL: flush_tok.kind = ktl_pkg::KIND_LABEL;
			ktl_pkg::MODE_INT:   flush_tok.kind = ktl_pkg::KIND_INT;
			default:             flush_tok.kind = ktl_pkg::word_kind(live_q, run_len_q);
		endcase
	end

	// Token of the byte itself, or END
	always_comb begin
		tok_vld         = 1'b0;
		byte_tok.kind   = ktl_pkg::KIND_INVALID;
		byte_tok.start  = off_ext[15:0];
		byte_tok.length = 16'd0;
		byte_tok.bad    = 8'd0;
		byte_tok.last   = 1'b0;
		if (eot) begin
			tok_vld       = 1'b1;
			byte_tok.kind = ktl_pkg::KIND_END;
		end else if (!(flush_vld || mode_q == ktl_pkg::MODE_IDLE)) begin
			tok_vld = 1'b0;
		end else if (b == ktl_pkg::CH_EQUAL) begin
			tok_vld       = 1'b1;
			byte_tok.kind = ktl_pkg::KIND_EQUAL;
		end else if (b == ktl_pkg::CH_PLUS) begin
			tok_vld       = 1'b1;
			byte_tok.kind = ktl_pkg::KIND_PLUS;
		end else if (b == ktl_pkg::CH_LESS) begin
			tok_vld       = 1'b1;
			byte_tok.kind = ktl_pkg::KIND_LESS;
		end else if (!(ktl_pkg::is_space(b) || ktl_pkg::is_word(b) ||
				b == ktl_pkg::CH_COLON)) begin
			tok_vld         = 1'b1;
			byte_tok.length = 16'd1;
			byte_tok.bad    = b;
		end
	end

	// Order the results and mark the last one
	always_comb begin
		n_res = 2'(flush_vld) + 2'(tok_vld);
		r0    = flush_vld ? flush_tok : byte_tok;
		r1    = byte_tok;
		r0.last = (n_res == 2'd1);
		r1.last = 1'b1;
	end

	// Advance the run state on each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ktl_pkg::MODE_IDLE;
			run_start_q <= '0;
			run_len_q   <= '0;
			live_q      <= ktl_pkg::LIVE_ALL;
			offset_q    <= '0;
		end else if (accept) begin
			if (eot) begin
				mode_q      <= ktl_pkg::MODE_IDLE;
				run_start_q <= '0;
				run_len_q   <= '0;
				live_q      <= ktl_pkg::LIVE_ALL;
				offset_q    <= '0;
			end else if (cont) begin
				if (mode_q == ktl_pkg::MODE_WORD)
					live_q <= ktl_pkg::kw_live_next(live_q, run_len_q, b);
				if (run_len_q != ktl_pkg::LEN_MAX)
					run_len_q <= run_len_q + 16'd1;
				offset_q <= off_inc;
			end else begin
				mode_q    <= ktl_pkg::MODE_IDLE;
				run_len_q <= '0;
				live_q    <= ktl_pkg::LIVE_ALL;
				if (b == ktl_pkg::CH_COLON) begin
					mode_q      <= ktl_pkg::MODE_LABEL;
					run_start_q <= off_inc;
				end else if (ktl_pkg::is_digit(b)) begin
					mode_q      <= ktl_pkg::MODE_INT;
					run_start_q <= offset_q;
					run_len_q   <= 16'd1;
				end else if (ktl_pkg::is_word(b)) begin
					mode_q      <= ktl_pkg::MODE_WORD;
					run_start_q <= offset_q;
					run_len_q   <= 16'd1;
					live_q      <= ktl_pkg::kw_live_next(ktl_pkg::LIVE_ALL, 16'd0, b);
				end
				offset_q <= off_inc;
			end
		end
	end

	// Output buffer fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (accept) begin
			count_q <= n_res;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	// Load or shift the output slots
	always_ff @(posedge clk) begin
		if (accept) begin
			slot0_q <= r0;
			slot1_q <= r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	assign m_axis_tvalid = (count_q != 2'd0);
	assign m_axis_tdata  = {4'd0, slot0_q.bad, slot0_q.length, slot0_q.start, slot0_q.kind};
	assign m_axis_tlast  = slot0_q.last;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_BYTES  = 640;
	localparam int DRAIN_CYCLES  = 12;
	localparam int LONG_INT_LEN  = 20;
	localparam int LONG_WORD_LEN = 14;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] text_byte
	logic        s_axis_tlast;   // end_of_text
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// [3:0] token_type, [19:4] token_start, [35:20] token_length,
	// [43:36] bad_byte, [47:44] zero
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;   // final_of_run

	// Lexer state as the predictor sees it
	logic [1:0]  lex_mode;
	logic [15:0] lex_start;
	logic [15:0] lex_len;
	logic [4:0]  lex_live;
	logic [15:0] lex_offset;

	ktl_pkg::token_t want_tokens [$];
	ktl_pkg::token_t step_tokens [$];
	int          errors;
	int          bytes_sent;
	int          cycle_count;
	bit          gaps_on;
	int          stall_left;

	string kw_spelling [ktl_pkg::KW_COUNT] = '{"input", "output", "goto", "if", "then"};

	keyword_token_lexer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Character classes
	function automatic bit digit_char(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit letter_char(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic bit word_char(input logic [7:0] b);
		return letter_char(b) || digit_char(b) || b == ktl_pkg::CH_UNDER;
	endfunction

	function automatic bit blank_char(input logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	// Keep the keywords whose spelling still agrees at position pos
	function automatic logic [4:0] narrow_live(input logic [4:0] live, input int pos,
			input logic [7:0] b);
		logic [4:0] keep;
		keep = '0;
		for (int k = 0; k < ktl_pkg::KW_COUNT; k++) begin
			if (live[k] && pos < kw_spelling[k].len() && kw_spelling[k][pos] == b)
				keep[k] = 1'b1;
		end
		return keep;
	endfunction

	function automatic ktl_pkg::token_t make_token(input logic [3:0] kind,
			input logic [15:0] start, input logic [15:0] len, input logic [7:0] bad);
		ktl_pkg::token_t t;
		t.kind   = kind;
		t.start  = start;
		t.length = len;
		t.bad    = bad;
		t.last   = 1'b0;
		return t;
	endfunction

	task automatic reset_lexer();
		lex_mode   = ktl_pkg::MODE_IDLE;
		lex_start  = '0;
		lex_len    = '0;
		lex_live   = ktl_pkg::LIVE_ALL;
		lex_offset = '0;
	endtask

	// Emit the pending run, if any, and return to between-tokens
	task automatic close_run();
		logic [3:0] kind;
		if (lex_mode == ktl_pkg::MODE_IDLE)
			return;
		kind = ktl_pkg::KIND_IDENT;
		if (lex_mode == ktl_pkg::MODE_LABEL) begin
			kind = ktl_pkg::KIND_LABEL;
		end else if (lex_mode == ktl_pkg::MODE_INT) begin
			kind = ktl_pkg::KIND_INT;
		end else begin
			for (int k = ktl_pkg::KW_COUNT - 1; k >= 0; k--) begin
				if (lex_live[k] && lex_len == kw_spelling[k].len())
					kind = ktl_pkg::KIND_KW0 + 4'(k);
			end
		end
		step_tokens.push_back(make_token(kind, lex_start, lex_len, 8'h00));
		lex_mode = ktl_pkg::MODE_IDLE;
		lex_len  = '0;
		lex_live = ktl_pkg::LIVE_ALL;
	endtask

	// Work out the tokens caused by one accepted request
	task automatic lex_request(input logic [7:0] b, input logic eot);
		bit cont;
		step_tokens.delete();
		if (eot) begin
			close_run();
			step_tokens.push_back(make_token(ktl_pkg::KIND_END, lex_offset, 16'd0, 8'h00));
			reset_lexer();
		end else begin
			cont = 1'b0;
			if (lex_mode != ktl_pkg::MODE_IDLE) begin
				cont = (lex_mode == ktl_pkg::MODE_INT) ? digit_char(b) : word_char(b);
				if (cont) begin
					if (lex_mode == ktl_pkg::MODE_WORD)
						lex_live = narrow_live(lex_live, int'(lex_len), b);
					if (lex_len != ktl_pkg::LEN_MAX)
						lex_len = lex_len + 16'd1;
				end else begin
					close_run();
				end
			end
			if (!cont) begin
				if (blank_char(b)) begin
					// skipped
				end else if (b == ktl_pkg::CH_EQUAL) begin
					step_tokens.push_back(make_token(ktl_pkg::KIND_EQUAL, lex_offset,
						16'd0, 8'h00));
				end else if (b == ktl_pkg::CH_PLUS) begin
					step_tokens.push_back(make_token(ktl_pkg::KIND_PLUS, lex_offset,
						16'd0, 8'h00));
				end else if (b == ktl_pkg::CH_LESS) begin
					step_tokens.push_back(make_token(ktl_pkg::KIND_LESS, lex_offset,
						16'd0, 8'h00));
				end else if (b == ktl_pkg::CH_COLON) begin
					lex_mode  = ktl_pkg::MODE_LABEL;
					lex_start = lex_offset + 16'd1;
					lex_len   = '0;
					lex_live  = ktl_pkg::LIVE_ALL;
				end else if (digit_char(b)) begin
					lex_mode  = ktl_pkg::MODE_INT;
					lex_start = lex_offset;
					lex_len   = 16'd1;
					lex_live  = ktl_pkg::LIVE_ALL;
				end else if (letter_char(b) || b == ktl_pkg::CH_UNDER) begin
					lex_mode  = ktl_pkg::MODE_WORD;
					lex_start = lex_offset;
					lex_len   = 16'd1;
					lex_live  = narrow_live(ktl_pkg::LIVE_ALL, 0, b);
				end else begin
					step_tokens.push_back(make_token(ktl_pkg::KIND_INVALID, lex_offset,
						16'd1, b));
				end
			end
			lex_offset = lex_offset + 16'd1;
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i])
			want_tokens.push_back(step_tokens[i]);
	endtask

	// Mostly short gaps, a few long ones, none while gaps are off
	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	// Send one request; entered and left at a falling edge
	task automatic send_request(input logic [7:0] b, input logic eot);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eot;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		lex_request(b, eot);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_request(s[i], 1'b0);
	endtask

	// Hold the sender off until every expected token has come
	task automatic wait_drained();
		if (want_tokens.size() != 0) begin
			s_axis_tvalid <= 1'b0;
			while (want_tokens.size() != 0)
				@(negedge clk);
		end
	endtask

	function automatic logic [7:0] random_word_char();
		int r;
		r = $urandom_range(0, 62);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		if (r < 62)
			return 8'("0" + r - 52);
		return ktl_pkg::CH_UNDER;
	endfunction

	function automatic logic [7:0] random_blank();
		int r;
		r = $urandom_range(8, 13);
		return (r == 8) ? 8'h20 : 8'(r);
	endfunction

	// Operators, keywords, empty label, invalid bytes, END over a pending run
	task automatic test_directed_tokens();
		gaps_on = 1'b1;
		send_text("if:=7+_Z<");
		send_request(8'h00, 1'b0);
		send_request(8'h80, 1'b0);
		send_request(8'hFF, 1'b0);
		send_request(8'h20, 1'b0);
		send_request(8'h09, 1'b0);
		send_text("then:");
		send_request(8'h7F, 1'b0);
		send_text("A");
		send_request(8'hFF, 1'b1);
	endtask

	// Long runs back to back, END on an empty text, a label after a blank
	task automatic test_long_runs();
		gaps_on = 1'b0;
		send_request(8'h00, 1'b1);
		send_request("9", 1'b0);
		for (int i = 1; i < LONG_INT_LEN; i++)
			send_request(8'("0" + $urandom_range(0, 9)), 1'b0);
		send_request("g", 1'b0);
		for (int i = 1; i < LONG_WORD_LEN; i++)
			send_request(random_word_char(), 1'b0);
		send_text(" :q=");
		send_request(8'h41, 1'b1);
	endtask

	// Mostly well-formed source text with random content, plus noise
	task automatic test_random_text();
		int    r;
		int    k;
		int    n;
		string w;
		bit    drained;
		drained = 1'b0;
		n = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < n) begin
			if ($urandom_range(0, 59) == 0)
				gaps_on = $urandom_range(0, 3) != 0;
			if (!drained && bytes_sent > n - RANDOM_BYTES / 2) begin
				wait_drained();
				drained = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 22) begin
				k = $urandom_range(0, ktl_pkg::KW_COUNT - 1);
				w = kw_spelling[k];
				case ($urandom_range(0, 5))
					0: w = w.substr(0, w.len() - 2);
					1: w = {w, string'(random_word_char())};
					2: w = w.toupper();
					default: ;
				endcase
				send_text(w);
			end else if (r < 36) begin
				send_request(($urandom_range(0, 4) == 0) ? ktl_pkg::CH_UNDER
					: 8'("a" + $urandom_range(0, 25)), 1'b0);
				repeat ($urandom_range(0, 7))
					send_request(random_word_char(), 1'b0);
			end else if (r < 48) begin
				repeat ($urandom_range(1, 6))
					send_request(8'("0" + $urandom_range(0, 9)), 1'b0);
			end else if (r < 58) begin
				send_request(ktl_pkg::CH_COLON, 1'b0);
				repeat ($urandom_range(0, 5))
					send_request(random_word_char(), 1'b0);
			end else if (r < 73) begin
				case ($urandom_range(0, 2))
					0: send_request(ktl_pkg::CH_EQUAL, 1'b0);
					1: send_request(ktl_pkg::CH_PLUS, 1'b0);
					default: send_request(ktl_pkg::CH_LESS, 1'b0);
				endcase
			end else if (r < 85) begin
				repeat ($urandom_range(1, 3))
					send_request(random_blank(), 1'b0);
			end else if (r < 96) begin
				send_request(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				send_request(8'($urandom_range(0, 255)), 1'b1);
			end
			if ($urandom_range(0, 1) == 0)
				send_request(random_blank(), 1'b0);
		end
	endtask

	// Compare one received token with the oldest expected one
	task automatic check_token(input logic [47:0] data, input logic last);
		ktl_pkg::token_t want;
		if (want_tokens.size() == 0) begin
			$error("unexpected token: tdata %h tlast %b", data, last);
			errors++;
			return;
		end
		want = want_tokens.pop_front();
		if (data[3:0] !== want.kind) begin
			$error("token_type: expected %0d, got %0d", want.kind, data[3:0]);
			errors++;
		end
		if (data[19:4] !== want.start) begin
			$error("token_start: expected %0d, got %0d", want.start, data[19:4]);
			errors++;
		end
		if (data[35:20] !== want.length) begin
			$error("token_length: expected %0d, got %0d", want.length, data[35:20]);
			errors++;
		end
		if (data[43:36] !== want.bad) begin
			$error("bad_byte: expected %h, got %h", want.bad, data[43:36]);
			errors++;
		end
		if (data[47:44] !== 4'h0) begin
			$error("tdata pad: expected 0, got %h", data[47:44]);
			errors++;
		end
		if (last !== want.last) begin
			$error("final_of_run: expected %b, got %b", want.last, last);
			errors++;
		end
	endtask

	// Take tokens as they are accepted
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_token(m_axis_tdata, m_axis_tlast);
	end

	// Stall the token stream at random
	initial begin
		m_axis_tready = 1'b0;
		stall_left    = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Give up after a generous number of cycles
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL keyword_token_lexer");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		errors        = 0;
		bytes_sent    = 0;
		gaps_on       = 1'b1;
		reset_lexer();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_tokens();
		test_long_runs();
		test_random_text();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (want_tokens.size() != 0) begin
			$error("%0d expected tokens never arrived", want_tokens.size());
			errors++;
		end
		if (errors == 0)
			$display("PASS keyword_token_lexer");
		else
			$display("FAIL keyword_token_lexer");
		$finish;
	end

endmodule
